// File: rtl/core/mvd_pkg.sv
// mvd_pkg: types, field widths and fixed constants of the magnetic vehicle detector
// no dependencies; imported by every module of the block
`default_nettype none

package mvd_pkg;

    localparam int FIELD_W    = 16;
    localparam int DEV_W      = 17;
    localparam int SQ_W       = 32;
    localparam int LVL_W      = 36;
    localparam int MAG_W      = 31;
    localparam int THRESH_W   = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 88;
    localparam int M_PAD_W    = M_TDATA_W - (1 + 3 * DEV_W + MAG_W);

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // level / 5 done in two pieces: high 16 bits, then remainder with low 18 bits
    localparam int HI_W   = 16;
    localparam int LO_W   = 18;
    localparam int QA_W   = 14;
    localparam int T_W    = 21;
    localparam int Q2_W   = 18;
    localparam int HI_K   = 19;
    localparam int LO_K   = 24;
    localparam int HI_P_W = 33;
    localparam int LO_P_W = 43;
    localparam logic [16:0]      DIV5_HI_RCP = 17'd104858;
    localparam logic [21:0]      DIV5_LO_RCP = 22'd3355444;
    localparam logic [LVL_W-1:0] SAT_LEVEL   = 36'd10737418240;
    localparam logic [MAG_W-1:0] MAG_MAX     = 31'h7FFF_FFFF;

    localparam logic [THRESH_W-1:0] THRESH_RESET    = 30'd14400;
    localparam logic [MAG_W-1:0]    BAND_LOW_RESET  = 31'd2500;
    localparam logic [MAG_W-1:0]    BAND_HIGH_RESET = 31'd6400;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd2;

    typedef enum logic [1:0] {
        STATUS_NORMAL = 2'd0,
        STATUS_STRONG = 2'd1,
        STATUS_BAND   = 2'd2,
        STATUS_CALIB  = 2'd3
    } result_code_t;

    typedef logic signed [DEV_W-1:0] dev_t;

    typedef struct packed {
        dev_t x;
        dev_t y;
        dev_t z;
    } dev3_t;

    typedef struct packed {
        logic valid;
        logic calib;
    } stage_t;

    typedef struct packed {
        logic accept;
        logic calib_in;
        logic det_done;
        logic cal_done;
        logic calib_a;
        logic valid_b;
        logic calib_b;
    } lane_ctl_t;

    typedef struct packed {
        result_code_t      status;
        logic              present;
        dev3_t             dev;
        logic [MAG_W-1:0]  magnitude;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/mvd_lane.sv
// mvd_lane: one axis lane - group sums, average by reciprocal, offset, square
// depends on mvd_pkg
`default_nettype none

module mvd_lane
    import mvd_pkg::*;
#(
    parameter int DETECT_SAMPLES = 3,
    parameter int CALIB_SAMPLES  = 10
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire lane_ctl_t                ctl,
    input  wire logic signed [FIELD_W-1:0] sample,
    output dev_t                          dev,
    output logic [SQ_W-1:0]               sq
);

    localparam int DET_SUM_W = FIELD_W + $clog2(DETECT_SAMPLES);
    localparam int CAL_SUM_W = FIELD_W + $clog2(CALIB_SAMPLES);
    localparam int ABS_W     = (DET_SUM_W > CAL_SUM_W) ? DET_SUM_W : CAL_SUM_W;
    localparam int GRP_W     = ABS_W + 1;
    localparam int DIV_K     = ABS_W + ABS_W - FIELD_W;
    localparam int RCP_W     = DIV_K + 1;
    localparam int PROD_W    = ABS_W + RCP_W;
    localparam logic [RCP_W-1:0] DET_RCP =
        RCP_W'(((64'd1 << DIV_K) + 64'(DETECT_SAMPLES - 1)) / 64'(DETECT_SAMPLES));
    localparam logic [RCP_W-1:0] CAL_RCP =
        RCP_W'(((64'd1 << DIV_K) + 64'(CALIB_SAMPLES - 1)) / 64'(CALIB_SAMPLES));

    logic signed [DET_SUM_W-1:0] det_sum_reg, det_sum_next, det_total;
    logic signed [CAL_SUM_W-1:0] cal_sum_reg, cal_sum_next, cal_total;
    logic signed [GRP_W-1:0]     grp_sum;
    logic [ABS_W-1:0]            grp_abs;
    logic [ABS_W-1:0]            abs_a_reg;
    logic                        neg_a_reg;
    logic [RCP_W-1:0]            rcp;
    logic [PROD_W-1:0]           prod;
    logic [FIELD_W-1:0]          quo_b_reg;
    logic                        neg_b_reg;
    logic signed [FIELD_W:0]     avg_full;
    logic signed [FIELD_W-1:0]   avg;
    logic signed [FIELD_W-1:0]   offset_reg, offset_next;
    dev_t                        dev_c_reg, dev_c_next, dev_d_reg;
    logic [FIELD_W-1:0]          dev_abs;
    logic [SQ_W-1:0]             sq_d_reg;

    always_comb begin
        det_total    = det_sum_reg + DET_SUM_W'(sample);
        cal_total    = cal_sum_reg + CAL_SUM_W'(sample);
        det_sum_next = det_sum_reg;
        cal_sum_next = cal_sum_reg;
        if (ctl.accept && !ctl.calib_in) begin
            det_sum_next = ctl.det_done ? '0 : det_total;
        end
        if (ctl.accept && ctl.calib_in) begin
            cal_sum_next = ctl.cal_done ? '0 : cal_total;
        end
        grp_sum = ctl.calib_in ? GRP_W'(cal_total) : GRP_W'(det_total);
        grp_abs = grp_sum[GRP_W-1] ? ABS_W'(-grp_sum) : ABS_W'(grp_sum);
    end

    // truncating average: |sum| * ceil(2^k / n) >> k, exact for this sum width
    assign rcp  = ctl.calib_a ? CAL_RCP : DET_RCP;
    assign prod = PROD_W'(abs_a_reg) * PROD_W'(rcp);

    always_comb begin
        avg_full    = neg_b_reg ? -$signed({1'b0, quo_b_reg}) : $signed({1'b0, quo_b_reg});
        avg         = avg_full[FIELD_W-1:0];
        dev_c_next  = ctl.calib_b ? DEV_W'(avg) : DEV_W'(avg) - DEV_W'(offset_reg);
        offset_next = (ctl.valid_b && ctl.calib_b) ? avg : offset_reg;
        dev_abs     = dev_c_reg[DEV_W-1] ? FIELD_W'(-dev_c_reg) : FIELD_W'(dev_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_sum_reg <= '0;
            cal_sum_reg <= '0;
            offset_reg  <= '0;
        end else begin
            det_sum_reg <= det_sum_next;
            cal_sum_reg <= cal_sum_next;
            offset_reg  <= offset_next;
        end
    end

    always_ff @(posedge aclk) begin
        abs_a_reg <= grp_abs;
        neg_a_reg <= grp_sum[GRP_W-1];
        quo_b_reg <= prod[DIV_K +: FIELD_W];
        neg_b_reg <= neg_a_reg;
        dev_c_reg <= dev_c_next;
        dev_d_reg <= dev_c_reg;
        sq_d_reg  <= SQ_W'(dev_abs) * SQ_W'(dev_abs);
    end

    assign dev = dev_d_reg;
    assign sq  = sq_d_reg;

endmodule

`default_nettype wire

// File: rtl/core/mvd_merge.sv
// mvd_merge: combines the lane squares into the weighted level, divides by 5,
// saturates and classifies; depends on mvd_pkg
`default_nettype none

module mvd_merge
    import mvd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire stage_t               stage_d,
    input  wire dev3_t                dev_d,
    input  wire logic [SQ_W-1:0]      sq_x,
    input  wire logic [SQ_W-1:0]      sq_y,
    input  wire logic [SQ_W-1:0]      sq_z,
    input  wire logic [THRESH_W-1:0]  thresh,
    input  wire logic [MAG_W-1:0]     band_low,
    input  wire logic [MAG_W-1:0]     band_high,
    output logic                      push,
    output result_t                   res
);

    stage_t              stage_e_reg, stage_f_reg, stage_g_reg, stage_h_reg;
    dev3_t               dev_e_reg, dev_f_reg, dev_g_reg, dev_h_reg;
    logic [LVL_W-1:0]    sq_xy, lvl;
    logic                sat_e_reg, sat_f_reg, sat_g_reg;
    logic [HI_W-1:0]     a_e_reg, a_f_reg;
    logic [LO_W-1:0]     b_e_reg, b_f_reg;
    logic [HI_P_W-1:0]   prod_hi;
    logic [QA_W-1:0]     qa_f_reg, qa_g_reg;
    logic [HI_W-1:0]     rem_hi;
    logic [T_W-1:0]      t_g_reg, t_g_next;
    logic [LO_P_W-1:0]   prod_lo;
    logic [Q2_W-1:0]     q2;
    logic [MAG_W-1:0]    mag_h_reg, mag_h_next;
    logic                above, over_twice, in_band;

    always_comb begin
        sq_xy    = LVL_W'(sq_x) + LVL_W'(sq_y);
        lvl      = sq_xy * LVL_W'(3) + LVL_W'(sq_z) * LVL_W'(9);
        prod_hi  = HI_P_W'(a_e_reg) * HI_P_W'(DIV5_HI_RCP);
        rem_hi   = a_f_reg - HI_W'(qa_f_reg) * HI_W'(5);
        t_g_next = {rem_hi[2:0], b_f_reg};
        prod_lo  = LO_P_W'(t_g_reg) * LO_P_W'(DIV5_LO_RCP);
        q2       = prod_lo[LO_K +: Q2_W];
        // below saturation the high quotient stays under 2^13
        mag_h_next = sat_g_reg ? MAG_MAX : {qa_g_reg[QA_W-2:0], q2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_e_reg <= '0;
            stage_f_reg <= '0;
            stage_g_reg <= '0;
            stage_h_reg <= '0;
        end else begin
            stage_e_reg <= stage_d;
            stage_f_reg <= stage_e_reg;
            stage_g_reg <= stage_f_reg;
            stage_h_reg <= stage_g_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dev_e_reg <= dev_d;
        dev_f_reg <= dev_e_reg;
        dev_g_reg <= dev_f_reg;
        dev_h_reg <= dev_g_reg;
        sat_e_reg <= (lvl >= SAT_LEVEL);
        a_e_reg   <= lvl[LO_W +: HI_W];
        b_e_reg   <= lvl[LO_W-1:0];
        sat_f_reg <= sat_e_reg;
        a_f_reg   <= a_e_reg;
        b_f_reg   <= b_e_reg;
        qa_f_reg  <= prod_hi[HI_K +: QA_W];
        sat_g_reg <= sat_f_reg;
        qa_g_reg  <= qa_f_reg;
        t_g_reg   <= t_g_next;
        mag_h_reg <= mag_h_next;
    end

    always_comb begin
        above      = mag_h_reg > MAG_W'(thresh);
        over_twice = mag_h_reg > {thresh, 1'b0};
        in_band    = (mag_h_reg > band_low) && (mag_h_reg < band_high);
        res.dev    = dev_h_reg;
        if (stage_h_reg.calib) begin
            res.status    = STATUS_CALIB;
            res.present   = 1'b0;
            res.magnitude = '0;
        end else begin
            res.present   = above;
            res.magnitude = mag_h_reg;
            if (in_band) begin
                res.status = STATUS_BAND;
            end else if (above && over_twice) begin
                res.status = STATUS_STRONG;
            end else begin
                res.status = STATUS_NORMAL;
            end
        end
    end

    assign push = stage_h_reg.valid;

endmodule

`default_nettype wire

// File: rtl/core/mvd_ofifo.sv
// mvd_ofifo: result queue between the pipeline and the m_ channel
// depends on mvd_pkg
`default_nettype none

module mvd_ofifo
    import mvd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t din,
    input  wire logic    pop,
    output logic         valid,
    output result_t      dout
);

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_pop;

    assign valid  = (count_reg != '0);
    assign dout   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb begin
        count_next = count_reg + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/magnetic_vehicle_detector.sv
// magnetic_vehicle_detector: top level - group counters, three axis lanes,
// merge stage, result queue and configuration registers
// depends on mvd_pkg, mvd_lane, mvd_merge, mvd_ofifo
//
// Samples enter on the s_ channel, one transfer per clock when s_tready is high.
// s_tuser selects calibration (1) or detect (0). Every DETECT_SAMPLES detect
// samples, or every CALIB_SAMPLES calibration samples, one result leaves on
// the m_ channel; other samples give no result. The result of the sample that
// completes its group moves through stages a to h and is then written to the queue.
// Throughput is one sample per cycle while s_tready is high: the x, y and z lanes
// run in parallel and the merge pipeline starts a new group every cycle. Results
// wait in a 16-entry queue; s_tready drops only while 16 results are in flight
// or queued, so a stalled receiver holds off the sender before the queue overflows.
// Configuration writes on cfg_ are taken every cycle (cfg_ready is high) and
// are meant for idle periods. Reset (aresetn low) clears group counts, sums,
// axis offsets, the queue and restores the default threshold and band.
`default_nettype none

module magnetic_vehicle_detector
    import mvd_pkg::*;
#(
    parameter int DETECT_SAMPLES = 3,
    parameter int CALIB_SAMPLES  = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // x_field, y_field, z_field
    input  wire logic                   s_tuser,   // mode
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // vehicle_present, x_dev, y_dev, z_dev,
                                                   // magnitude, zero pad
    output logic [1:0]                  m_tuser,   // status
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DCNT_W = $clog2(DETECT_SAMPLES + 1);
    localparam int CCNT_W = $clog2(CALIB_SAMPLES + 1);
    localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

    logic [DCNT_W-1:0]   det_cnt_reg, det_cnt_next;
    logic [CCNT_W-1:0]   cal_cnt_reg, cal_cnt_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic [THRESH_W-1:0] thresh_reg;
    logic [MAG_W-1:0]    band_low_reg, band_high_reg;
    stage_t              stage_a_reg, stage_b_reg, stage_c_reg, stage_d_reg, stage_a_next;
    logic                accept, det_done, cal_done, issue, pop;
    lane_ctl_t           lane_ctl;
    dev3_t               dev_d;
    logic [SQ_W-1:0]     sq_x, sq_y, sq_z;
    logic                push;
    result_t             res, head;

    assign accept   = s_tvalid && s_tready;
    assign det_done = (det_cnt_reg == DCNT_W'(DETECT_SAMPLES - 1));
    assign cal_done = (cal_cnt_reg == CCNT_W'(CALIB_SAMPLES - 1));
    assign issue    = accept && (s_tuser ? cal_done : det_done);
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (pend_reg < PEND_W'(FIFO_DEPTH));

    always_comb begin
        det_cnt_next = det_cnt_reg;
        cal_cnt_next = cal_cnt_reg;
        if (accept && !s_tuser) begin
            det_cnt_next = det_done ? '0 : det_cnt_reg + 1'b1;
        end
        if (accept && s_tuser) begin
            cal_cnt_next = cal_done ? '0 : cal_cnt_reg + 1'b1;
        end
        pend_next          = pend_reg + PEND_W'(issue) - PEND_W'(pop);
        stage_a_next.valid = issue;
        stage_a_next.calib = s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_cnt_reg   <= '0;
            cal_cnt_reg   <= '0;
            pend_reg      <= '0;
            stage_a_reg   <= '0;
            stage_b_reg   <= '0;
            stage_c_reg   <= '0;
            stage_d_reg   <= '0;
            thresh_reg    <= THRESH_RESET;
            band_low_reg  <= BAND_LOW_RESET;
            band_high_reg <= BAND_HIGH_RESET;
        end else begin
            det_cnt_reg <= det_cnt_next;
            cal_cnt_reg <= cal_cnt_next;
            pend_reg    <= pend_next;
            stage_a_reg <= stage_a_next;
            stage_b_reg <= stage_a_reg;
            stage_c_reg <= stage_b_reg;
            stage_d_reg <= stage_c_reg;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: thresh_reg    <= cfg_data[THRESH_W-1:0];
                    REG_BAND_LOW:  band_low_reg  <= cfg_data[MAG_W-1:0];
                    REG_BAND_HIGH: band_high_reg <= cfg_data[MAG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg_ready = 1'b1;

    always_comb begin
        lane_ctl.accept   = accept;
        lane_ctl.calib_in = s_tuser;
        lane_ctl.det_done = det_done;
        lane_ctl.cal_done = cal_done;
        lane_ctl.calib_a  = stage_a_reg.calib;
        lane_ctl.valid_b  = stage_b_reg.valid;
        lane_ctl.calib_b  = stage_b_reg.calib;
    end

    mvd_lane #(
        .DETECT_SAMPLES (DETECT_SAMPLES),
        .CALIB_SAMPLES  (CALIB_SAMPLES)
    ) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_tdata[15:0]),
        .dev     (dev_d.x),
        .sq      (sq_x)
    );

    mvd_lane #(
        .DETECT_SAMPLES (DETECT_SAMPLES),
        .CALIB_SAMPLES  (CALIB_SAMPLES)
    ) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_tdata[31:16]),
        .dev     (dev_d.y),
        .sq      (sq_y)
    );

    mvd_lane #(
        .DETECT_SAMPLES (DETECT_SAMPLES),
        .CALIB_SAMPLES  (CALIB_SAMPLES)
    ) u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_tdata[47:32]),
        .dev     (dev_d.z),
        .sq      (sq_z)
    );

    mvd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage_d   (stage_d_reg),
        .dev_d     (dev_d),
        .sq_x      (sq_x),
        .sq_y      (sq_y),
        .sq_z      (sq_z),
        .thresh    (thresh_reg),
        .band_low  (band_low_reg),
        .band_high (band_high_reg),
        .push      (push),
        .res       (res)
    );

    mvd_ofifo u_ofifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (res),
        .pop     (pop),
        .valid   (m_tvalid),
        .dout    (head)
    );

    assign m_tuser = head.status;
    assign m_tdata = {{M_PAD_W{1'b0}}, head.magnitude, head.dev.z, head.dev.y, head.dev.x,
                      head.present};

endmodule

`default_nettype wire

// File: dv/magnetic_vehicle_detector_test.sv
// magnetic_vehicle_detector_test: self-checking testbench for the magnetic vehicle detector
// predicts group averages, offsets, weighted level and status per sample transfer
// depends on mvd_pkg and magnetic_vehicle_detector
`timescale 1ns / 1ps

module magnetic_vehicle_detector_test;
    import mvd_pkg::*;

    localparam int DET_GROUP      = 3;
    localparam int CAL_GROUP      = 10;
    localparam longint LEVEL_CEIL = 64'h7FFF_FFFF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_SAMPLES  = 271;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        result_code_t      status;
        bit                present;
        dev_t              x;
        dev_t              y;
        dev_t              z;
        logic [MAG_W-1:0]  level;
    } detector_result_t;

    class detection_scoreboard;
        longint threshold;
        longint band_lo;
        longint band_hi;
        int unsigned det_count;
        int unsigned cal_count;
        longint det_sum[3];
        longint cal_sum[3];
        longint offset[3];
        detector_result_t pending[$];
        int mismatches;
        int results_seen;
        int calibrations;
        int samples_taken;

        function new();
            threshold = THRESH_RESET;
            band_lo   = BAND_LOW_RESET;
            band_hi   = BAND_HIGH_RESET;
            det_count = 0;
            cal_count = 0;
            for (int j = 0; j < 3; j++) begin
                det_sum[j] = 0;
                cal_sum[j] = 0;
                offset[j]  = 0;
            end
            mismatches    = 0;
            results_seen  = 0;
            calibrations  = 0;
            samples_taken = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD: threshold = data[THRESH_W-1:0];
                REG_BAND_LOW:  band_lo   = data[MAG_W-1:0];
                REG_BAND_HIGH: band_hi   = data[MAG_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(bit calib, logic signed [FIELD_W-1:0] x,
                                  logic signed [FIELD_W-1:0] y,
                                  logic signed [FIELD_W-1:0] z);
            longint v[3];
            longint d[3];
            longint sq[3];
            longint lvl;
            detector_result_t r;
            v[0] = x;
            v[1] = y;
            v[2] = z;
            samples_taken++;
            if (calib) begin
                for (int j = 0; j < 3; j++) cal_sum[j] += v[j];
                cal_count++;
                if (cal_count < CAL_GROUP) return;
                cal_count = 0;
                for (int j = 0; j < 3; j++) begin
                    offset[j]  = cal_sum[j] / CAL_GROUP;
                    cal_sum[j] = 0;
                end
                r.status  = STATUS_CALIB;
                r.present = 1'b0;
                r.x       = DEV_W'(offset[0]);
                r.y       = DEV_W'(offset[1]);
                r.z       = DEV_W'(offset[2]);
                r.level   = '0;
                calibrations++;
            end else begin
                for (int j = 0; j < 3; j++) det_sum[j] += v[j];
                det_count++;
                if (det_count < DET_GROUP) return;
                det_count = 0;
                for (int j = 0; j < 3; j++) begin
                    d[j]       = det_sum[j] / DET_GROUP - offset[j];
                    det_sum[j] = 0;
                    sq[j]      = d[j] * d[j];
                end
                lvl = (3 * sq[0] + 3 * sq[1] + 9 * sq[2]) / 5;
                if (lvl > LEVEL_CEIL) lvl = LEVEL_CEIL;
                r.status  = STATUS_NORMAL;
                r.present = 1'b0;
                if (lvl > threshold) begin
                    r.present = 1'b1;
                    if (lvl > 2 * threshold) r.status = STATUS_STRONG;
                end
                // band wins over strong
                if (lvl > band_lo && lvl < band_hi) r.status = STATUS_BAND;
                r.x     = DEV_W'(d[0]);
                r.y     = DEV_W'(d[1]);
                r.z     = DEV_W'(d[2]);
                r.level = MAG_W'(lvl);
            end
            pending.push_back(r);
        endfunction

        function void report(string what, detector_result_t e, detector_result_t a);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch: %s exp st=%0d pv=%0d dev=%0d/%0d/%0d lvl=%0d",
                         $realtime, what, e.status, e.present, e.x, e.y, e.z, e.level);
                $display("    got st=%0d pv=%0d dev=%0d/%0d/%0d lvl=%0d",
                         a.status, a.present, a.x, a.y, a.z, a.level);
            end
        endfunction

        function void check_result(detector_result_t a);
            detector_result_t e;
            results_seen++;
            if (pending.size() == 0) begin
                e = '{STATUS_NORMAL, 1'b0, '0, '0, '0, '0};
                report("result with nothing expected", e, a);
                return;
            end
            e = pending.pop_front();
            if (e.status !== a.status || e.present !== a.present || e.x !== a.x ||
                e.y !== a.y || e.z !== a.z || e.level !== a.level)
                report("wrong field", e, a);
        endfunction

        function void close_out();
            detector_result_t a;
            a = '{STATUS_NORMAL, 1'b0, '0, '0, '0, '0};
            while (pending.size() != 0) report("result never arrived", pending.pop_front(), a);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    detection_scoreboard sb;
    bit calm;
    bit hold_request;

    magnetic_vehicle_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("magnetic_vehicle_detector_test NOT OK");
        $finish;
    end

    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        detector_result_t got;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.status  = result_code_t'(m_tuser);
                got.present = m_tdata[0];
                got.x       = m_tdata[1 +: DEV_W];
                got.y       = m_tdata[1 + DEV_W +: DEV_W];
                got.z       = m_tdata[1 + 2 * DEV_W +: DEV_W];
                got.level   = m_tdata[1 + 3 * DEV_W +: MAG_W];
                sb.check_result(got);
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic send_sample(input bit calib, input logic signed [FIELD_W-1:0] x,
                               input logic signed [FIELD_W-1:0] y,
                               input logic signed [FIELD_W-1:0] z);
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= calib;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(calib, x, y, z);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr, lo, hi);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_BAND_LOW, lo);
        write_reg(REG_BAND_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    // stop offering and let every outstanding result and the pipeline tail drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_axis(int centre);
        int v;
        int spread;
        if ($urandom_range(99) < 18) begin
            case ($urandom_range(5))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                3: v = -1;
                default: v = int'($urandom_range(65535)) - 32768;
            endcase
        end else begin
            case ($urandom_range(2))
                0: spread = 8;
                1: spread = 60;
                default: spread = 250;
            endcase
            v = centre + int'($urandom_range(2 * spread)) - spread;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
        end
        return FIELD_W'(v);
    endfunction

    task automatic run_random(input int count);
        int cx;
        int cy;
        int cz;
        cx = int'($urandom_range(2000)) - 1000;
        cy = int'($urandom_range(2000)) - 1000;
        cz = int'($urandom_range(2000)) - 1000;
        repeat (count)
            send_sample($urandom_range(99) < 12, pick_axis(cx), pick_axis(cy), pick_axis(cz));
    endtask

    initial begin : stimulus
        sb = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // zero level, mid band, strong, saturation at default settings
        repeat (3) send_sample(1'b0, 0, 0, 0);
        repeat (3) send_sample(1'b0, 50, 50, 0);
        repeat (3) send_sample(1'b0, 300, 0, 0);
        repeat (3) send_sample(1'b0, -32768, -32768, -32768);
        // calibration lands inside a detect group; y average truncates toward zero
        send_sample(1'b0, 32767, 32767, 32767);
        for (int i = 0; i < CAL_GROUP; i++)
            send_sample(1'b1, -32768, (i == 4) ? -15 : 0, (i == 7) ? 7 : 0);
        repeat (2) send_sample(1'b0, 32767, 32767, 32767);
        run_random(PHASE_SAMPLES);
        drain();

        apply_settings(32'd0, 32'd0, 32'd0);
        calm = 1'b1;
        run_random(PHASE_SAMPLES);
        drain();
        calm = 1'b0;

        // bits above the threshold and band high register widths, plus an unmapped index
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        apply_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        run_random(PHASE_SAMPLES);
        drain();

        apply_settings($urandom_range(20000), $urandom_range(5000),
                       5000 + $urandom_range(20000));
        hold_request = 1'b1;
        run_random(PHASE_SAMPLES);
        drain();

        apply_settings($urandom(), $urandom(), $urandom());
        run_random(PHASE_SAMPLES);
        drain();

        // band sits above the strong level
        apply_settings(32'd2000, 32'd5000, 32'd100000);
        run_random(PHASE_SAMPLES);
        drain();

        sb.close_out();
        $display("covered %0d samples over six register settings: %0d results, %0d calibrations",
                 sb.samples_taken, sb.results_seen, sb.calibrations);
        $display("receiver hold of %0d cycles applied once; %0d mismatches",
                 HOLD_CYCLES, sb.mismatches);
        if (sb.mismatches == 0)
            $display("magnetic_vehicle_detector_test OK");
        else
            $display("magnetic_vehicle_detector_test NOT OK");
        $finish;
    end

endmodule
